>>> src/pfr_pkg.sv
// pfr_pkg: shared sizes, codes, types and helpers of the page frame table
// used by every module of page_frame_replacement and by its checker
package pfr_pkg;

    localparam int FRAME_COUNT = 16;
    localparam int PAGE_BITS   = 16;

    localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(FRAME_COUNT + 1);

    // field widths on the ports
    localparam int PAGE_FIELD_W = 16;
    localparam int SLOT_W       = 4;
    localparam int COUNT_W      = 16;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 1;

    localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(FRAME_COUNT - 1);
    localparam logic [RANK_W:0]   RANK_NONE = (RANK_W + 1)'(FRAME_COUNT);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd1;

    // replacement policies
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } pfr_state_t;

    // carry that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 found;
        logic [IDX_W-1:0]     hit_idx;
        logic [RANK_W-1:0]    hit_rank;
        logic                 empty_found;
        logic [IDX_W-1:0]     empty_idx;
        logic                 lru_any;
        logic [IDX_W-1:0]     lru_idx;
        logic [RANK_W-1:0]    lru_rank;
        logic [PAGE_BITS-1:0] lru_page;
        logic [PAGE_BITS-1:0] fifo_page;
    } pfr_scan_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                 clear;
        logic                 commit;
        logic                 fill;
        logic [IDX_W-1:0]     idx;
        logic [RANK_W:0]      old_rank;
        logic [PAGE_BITS-1:0] page;
        logic [IDX_W-1:0]     fifo_idx;
    } pfr_cmd_t;

    function automatic logic [PAGE_BITS-1:0] field_to_page(input logic [PAGE_FIELD_W-1:0] f);
        logic [31:0] w;
        w = 32'(f);
        return w[PAGE_BITS-1:0];
    endfunction

    function automatic logic [PAGE_FIELD_W-1:0] page_to_field(input logic [PAGE_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[PAGE_FIELD_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] i);
        logic [31:0] w;
        w = 32'(i);
        return w[SLOT_W-1:0];
    endfunction

endpackage

>>> src/pfr_cell.sv
// pfr_cell: one frame of the table (page, valid, recency rank) plus one
// registered stage of the search carry; depends on pfr_pkg
module pfr_cell
    import pfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             active,
    input  logic [IDX_W-1:0] index,
    input  pfr_cmd_t         cmd,
    input  pfr_scan_t        scan_in,
    output pfr_scan_t        scan_out
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [RANK_W-1:0]    rank_reg;
    pfr_scan_t            scan_reg;
    pfr_scan_t            scan_next;

    logic is_target;
    logic hit_here;
    logic empty_here;
    logic lru_here;
    logic ages;

    assign is_target  = (index == cmd.idx);
    assign hit_here   = active && valid_reg && (page_reg == scan_in.page) && !scan_in.found;
    assign empty_here = active && !valid_reg && !scan_in.empty_found;
    assign lru_here   = active && (!scan_in.lru_any || (rank_reg > scan_in.lru_rank));
    assign ages       = valid_reg && ({1'b0, rank_reg} < cmd.old_rank) && (rank_reg < RANK_MAX);

    always_comb
    begin
        scan_next = scan_in;
        if (hit_here)
        begin
            scan_next.found    = 1'b1;
            scan_next.hit_idx  = index;
            scan_next.hit_rank = rank_reg;
        end
        if (empty_here)
        begin
            scan_next.empty_found = 1'b1;
            scan_next.empty_idx   = index;
        end
        if (lru_here)
        begin
            scan_next.lru_any  = 1'b1;
            scan_next.lru_idx  = index;
            scan_next.lru_rank = rank_reg;
            scan_next.lru_page = page_reg;
        end
        if (index == cmd.fifo_idx)
        begin
            scan_next.fifo_page = page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (cmd.commit && active)
        begin
            if (is_target)
            begin
                rank_reg <= '0;
                if (cmd.fill)
                begin
                    valid_reg <= 1'b1;
                end
            end
            else if (ages)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    // page store: only read back from valid frames
    always_ff @(posedge clk)
    begin
        if (cmd.commit && active && is_target && cmd.fill)
        begin
            page_reg <= cmd.page;
        end
    end

endmodule

>>> src/pfr_ctrl.sv
// pfr_ctrl: sequencer of page_frame_replacement: takes a reference, waits
// for the carry to clear the cell chain, then commits once out_free; depends on pfr_pkg
module pfr_ctrl
    import pfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_free,
    output logic in_ready,
    output logic commit
);

    pfr_state_t       state_reg;
    pfr_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             scan_done;

    assign scan_done = (cnt_reg == CNT_W'(FRAME_COUNT));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        commit   = 1'b0;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
            end
            ST_SCAN:
            begin
                commit = scan_done && out_free;
                if (!scan_done)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> src/page_frame_replacement.sv
// page_frame_replacement: fully associative page frame table with FIFO or
// LRU replacement, built as a chain of frame cells; depends on pfr_pkg,
// pfr_cell and pfr_ctrl
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid / tready        page_number, new_string
//  m_axis    out        m_axis_tvalid / tready        slot, pages, counts, flags
//  cfg       in         cfg_valid / cfg_ready         cfg_index, cfg_data
//
// one reference at a time: a transfer on s_axis, then the search carry walks
// the FRAME_COUNT cells one per cycle, then the commit follows
// the result sits in an output register, so the next reference is taken
// while m_axis is stalled; only the commit waits for a free output register
// rst_n clears every frame, the ranks, the fifo pointer, the counts and the
// registers (policy lru, 16 frames); no clearing pass is needed
// cfg is always ready and is meant to be written while the block is idle
module page_frame_replacement
    import pfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] page_number
    input  logic [0:0]            s_axis_tuser,   // [0] new_string

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [55:0]           m_axis_tdata,   // [3:0] slot, [19:4] evicted_page,
                                                  // [35:20] fault_count,
                                                  // [51:36] hit_count, [55:52] zero
    output logic [1:0]            m_axis_tuser,   // [0] hit, [1] evicted_valid

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic                  policy_reg;
    logic [CFG_DATA_W-1:0] frames_reg;

    // table-wide state
    logic [IDX_W-1:0]     ptr_reg;
    logic [COUNT_W-1:0]   faults_reg;
    logic [COUNT_W-1:0]   hits_reg;
    logic [PAGE_BITS-1:0] page_hold_reg;

    // output register
    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic                    out_ev_valid_reg;
    logic [PAGE_FIELD_W-1:0] out_ev_page_reg;
    logic [COUNT_W-1:0]      out_faults_reg;
    logic [COUNT_W-1:0]      out_hits_reg;

    logic             in_accept;
    logic             out_free;
    logic             commit;
    logic [CNT_W-1:0] eff_n;
    logic [IDX_W-1:0] fifo_idx;
    logic [FRAME_COUNT-1:0] active;

    pfr_scan_t chain [FRAME_COUNT+1];
    pfr_scan_t head;
    pfr_scan_t tail;
    pfr_cmd_t  cmd;

    // commit decisions
    logic [IDX_W-1:0]     target;
    logic                 evict;
    logic [PAGE_BITS-1:0] ev_page;
    logic [CNT_W-1:0]     ptr_step;
    logic [IDX_W-1:0]     ptr_next;
    logic [COUNT_W-1:0]   faults_next;
    logic [COUNT_W-1:0]   hits_next;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_LRU;
            frames_reg <= CFG_DATA_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLICY_MODE:   policy_reg <= cfg_data[0];
                CFG_FRAMES_IN_USE: frames_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // frame count clamped to 1..FRAME_COUNT
    always_comb
    begin
        if (frames_reg == '0)
        begin
            eff_n = CNT_W'(1);
        end
        else if (32'(frames_reg) > FRAME_COUNT)
        begin
            eff_n = CNT_W'(FRAME_COUNT);
        end
        else
        begin
            eff_n = CNT_W'(frames_reg);
        end
    end

    // fifo pointer outside the count acts as frame zero
    assign fifo_idx = (CNT_W'(ptr_reg) < eff_n) ? ptr_reg : '0;

    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .in_ready (s_axis_tready),
        .commit   (commit)
    );

    // carry enters the chain with the held page and nothing found yet
    always_comb
    begin
        head      = '0;
        head.page = page_hold_reg;
    end

    assign chain[0] = head;

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_COUNT; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] CELL_POS = CNT_W'(gi);
            localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(gi);

            assign active[gi] = (CELL_POS < eff_n);

            pfr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (active[gi]),
                .index    (CELL_IDX),
                .cmd      (cmd),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi+1])
            );
        end
    endgenerate

    // the last stage holds the full search once the carry has passed every cell
    assign tail = chain[FRAME_COUNT];

    always_comb
    begin
        evict   = 1'b0;
        ev_page = '0;
        if (tail.found)
        begin
            target = tail.hit_idx;
        end
        else if (tail.empty_found)
        begin
            target = tail.empty_idx;
        end
        else if (policy_reg == POLICY_LRU)
        begin
            target  = tail.lru_idx;
            evict   = 1'b1;
            ev_page = tail.lru_page;
        end
        else
        begin
            target  = fifo_idx;
            evict   = 1'b1;
            ev_page = tail.fifo_page;
        end
    end

    // pointer advances only on a fifo replacement, wrapping at the count
    assign ptr_step = CNT_W'(fifo_idx) + 1'b1;
    assign ptr_next = (ptr_step < eff_n) ? IDX_W'(ptr_step) : '0;

    // counts saturate
    assign faults_next = (!tail.found && (faults_reg != COUNT_MAX)) ? faults_reg + 1'b1
                                                                   : faults_reg;
    assign hits_next   = (tail.found && (hits_reg != COUNT_MAX)) ? hits_reg + 1'b1 : hits_reg;

    always_comb
    begin
        cmd.clear    = in_accept && s_axis_tuser[0];
        cmd.commit   = commit;
        cmd.fill     = !tail.found;
        cmd.idx      = target;
        cmd.old_rank = tail.found ? {1'b0, tail.hit_rank} : RANK_NONE;
        cmd.page     = page_hold_reg;
        cmd.fifo_idx = fifo_idx;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            page_hold_reg <= field_to_page(s_axis_tdata[PAGE_FIELD_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            faults_reg <= '0;
            hits_reg   <= '0;
        end
        else if (in_accept && s_axis_tuser[0])
        begin
            ptr_reg    <= '0;
            faults_reg <= '0;
            hits_reg   <= '0;
        end
        else if (commit)
        begin
            faults_reg <= faults_next;
            hits_reg   <= hits_next;
            if (evict && (policy_reg == POLICY_FIFO))
            begin
                ptr_reg <= ptr_next;
            end
        end
    end

    // output register: loaded on commit, held until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_hit_reg      <= tail.found;
            out_slot_reg     <= idx_to_slot(target);
            out_ev_valid_reg <= evict;
            out_ev_page_reg  <= page_to_field(ev_page);
            out_faults_reg   <= faults_next;
            out_hits_reg     <= hits_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_ev_valid_reg, out_hit_reg};
    assign m_axis_tdata  = {4'b0000, out_hits_reg, out_faults_reg, out_ev_page_reg,
                            out_slot_reg};

endmodule

>>> src/pfr_checker.sv
// pfr_checker: port-level checks of page_frame_replacement, bound to the
// top level; depends on pfr_pkg
module pfr_checker
    import pfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one reference at a time: input closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second reference taken during a search");

    // a hit never evicts, and no eviction reports a page
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] || !m_axis_tuser[1]) |->
            !m_axis_tuser[1] && (m_axis_tdata[19:4] == '0))
        else $error("eviction fields inconsistent with hit");

    // the count matching the outcome is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser[0] && (m_axis_tdata[51:36] != '0)) ||
            (!m_axis_tuser[0] && (m_axis_tdata[35:20] != '0)))
        else $error("count does not reflect this result");

endmodule

bind page_frame_replacement pfr_checker u_pfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
